/* sv/calendar_date_step_counter_defines.svh */
// Assertion macros shared by the date counter checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef CALENDAR_DATE_STEP_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_STEP_COUNTER_DEFINES_SVH

// Check a property on every clock, ignored while reset is high
`define CDSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock, reset included
`define CDSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cdsc_pkg.sv */
// Shared types, constants and calendar helper functions for the date counter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cdsc_pkg;

  // Field widths fixed by the stream format
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int LOAD_YEAR_W = 14;
  localparam int OP_W        = 2;

  // Opcodes carried in s_tuser
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd1;
  localparam logic [OP_W-1:0] OP_PREV  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // Calendar constants
  localparam int GREG_START  = 1582;  // first year with the century rule
  localparam int CENTURY_ODD = 25;    // 100 = 4 * 25, 400 = 16 * 25
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;

  // Month lies in January..December
  function automatic logic month_ok(input month_t m);
    return (m >= 4'd1) && (m <= LAST_MONTH);
  endfunction

  // Length of a month; months outside 1..12 report 31
  function automatic day_t days_in_month(input month_t m, input logic feb29_ok);
    day_t n;
    n = LAST_DAY;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      n = 5'd30;
    end else if (m == 4'd2) begin
      n = feb29_ok ? 5'd29 : 5'd28;
    end
    return n;
  endfunction

  // Full date check; day is one bit wider so that 32 reads as invalid
  function automatic logic date_ok(input logic [DAY_W:0] d, input month_t m,
                                   input logic feb29_ok);
    return month_ok(m) && (d != '0) && (d <= {1'b0, days_in_month(m, feb29_ok)});
  endfunction

endpackage

/* sv/cdsc_leap.sv */
// February 29 test for one year: always valid before 1582, Gregorian after.
// Depends on cdsc_pkg for calendar constants.
`timescale 1ns / 1ps

module cdsc_leap #(
  parameter int YEAR_BITS = 14
) (
  input  logic [YEAR_BITS-1:0] year,
  output logic                 feb29_ok
);

  // Inverse of an odd number modulo 2^32 by Newton steps, worked out at elaboration
  function automatic logic [31:0] inv_odd32(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int i = 0; i < 4; i++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

  localparam logic [YEAR_BITS-1:0] Inv25 =
    YEAR_BITS'(inv_odd32(32'(cdsc_pkg::CENTURY_ODD)));
  localparam logic [YEAR_BITS-1:0] Div25Max =
    YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / cdsc_pkg::CENTURY_ODD);
  localparam logic [YEAR_BITS-1:0] GregStart = YEAR_BITS'(cdsc_pkg::GREG_START);

  logic [YEAR_BITS-1:0] prod;
  logic div4, div16, div25, leap;

  // Divisible by 25 when year * inverse(25) wraps into the low band
  assign prod  = year * Inv25;
  assign div25 = (prod <= Div25Max);
  assign div4  = (year[1:0] == 2'b00);
  assign div16 = (year[3:0] == 4'b0000);

  // Century years leap only when divisible by 400
  assign leap     = div4 && (!div25 || div16);
  assign feb29_ok = (year < GregStart) || leap;

endmodule

/* sv/calendar_date_step_counter.sv */
// Top level of the day/month/year step counter with stream ports.
// Depends on cdsc_pkg and cdsc_leap.
`timescale 1ns / 1ps
//
//  channel  dir  beat carries
//  -------  ---  ------------------------------------------------------
//  s_*      in   opcode in tuser; load day, month, year in tdata
//  m_*      out  stored day, month, year in tdata; date valid in tuser
//
//  One beat per cycle unless the sink stalls: each accepted beat updates the date
//  and fills the result register on the same edge, so the result shows in the next cycle.
//  The date update is a single pass through the leap test and day/month logic.
//  rst clears the date to 0/0/0 and empties the result register.
//  s_tready is low only while a result waits and m_tready is low.

module calendar_date_step_counter #(
  parameter int YEAR_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // load_day[4:0], load_month[8:5], load_year[22:9], zero pad
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // day_out[4:0], month_out[8:5], year_out[22:9], zero pad
  output logic        m_tuser    // date_valid[0]
);

  localparam int DW = cdsc_pkg::DAY_W;
  localparam int MW = cdsc_pkg::MONTH_W;
  localparam int LW = cdsc_pkg::LOAD_YEAR_W;

  // Stored date
  cdsc_pkg::day_t       day_reg, day_next;
  cdsc_pkg::month_t     month_reg, month_next;
  logic [YEAR_BITS-1:0] year_reg, year_next;

  // Result register
  cdsc_pkg::day_t       day_out;
  cdsc_pkg::month_t     month_out;
  logic [LW-1:0]        year_out;
  logic                 date_valid;

  // Unpacked beat
  logic [cdsc_pkg::OP_W-1:0] opcode;
  cdsc_pkg::day_t            load_day;
  cdsc_pkg::month_t          load_month;
  logic [LW-1:0]             load_year;

  logic                 accept;
  logic [YEAR_BITS-1:0] sel_year;
  logic                 feb29_ok;
  logic [DW:0]          day_inc;
  cdsc_pkg::day_t       day_dec;
  cdsc_pkg::month_t     month_inc, month_dec;
  logic                 valid_next;

  assign opcode     = s_tuser;
  assign load_day   = s_tdata[DW-1:0];
  assign load_month = s_tdata[DW+MW-1:DW];
  assign load_year  = s_tdata[DW+MW+LW-1:DW+MW];

  // Take a beat whenever the result register is empty or draining
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // One leap test serves both the step and the new date's check
  assign sel_year = (opcode == cdsc_pkg::OP_LOAD) ? YEAR_BITS'(load_year) : year_reg;

  cdsc_leap #(.YEAR_BITS(YEAR_BITS)) u_leap (
    .year     (sel_year),
    .feb29_ok (feb29_ok)
  );

  assign day_inc   = {1'b0, day_reg} + 1'b1;
  assign day_dec   = day_reg - 1'b1;
  assign month_inc = month_reg + 1'b1;
  assign month_dec = month_reg - 1'b1;

  // Work out the date after this beat's operation
  always_comb begin
    day_next   = day_reg;
    month_next = month_reg;
    year_next  = year_reg;
    case (opcode)
      cdsc_pkg::OP_LOAD: begin
        day_next   = load_day;
        month_next = load_month;
        year_next  = YEAR_BITS'(load_year);
      end
      cdsc_pkg::OP_NEXT: begin
        if (cdsc_pkg::date_ok(day_inc, month_reg, feb29_ok)) begin
          day_next = day_inc[DW-1:0];
        end else begin
          day_next = DW'(1);
          if (cdsc_pkg::month_ok(month_inc)) begin
            month_next = month_inc;
          end else begin
            month_next = MW'(1);
            year_next  = year_reg + 1'b1;
          end
        end
      end
      cdsc_pkg::OP_PREV: begin
        if ((day_reg != '0) && cdsc_pkg::date_ok({1'b0, day_dec}, month_reg, feb29_ok)) begin
          day_next = day_dec;
        end else if (month_dec == '0) begin
          day_next   = cdsc_pkg::LAST_DAY;
          month_next = cdsc_pkg::LAST_MONTH;
          year_next  = year_reg - 1'b1;
        end else begin
          // Land on the month's last day; a month with no valid day stops at 1
          month_next = month_dec;
          day_next   = cdsc_pkg::month_ok(month_dec)
                       ? cdsc_pkg::days_in_month(month_dec, feb29_ok) : DW'(1);
        end
      end
      default: begin
        // Query leaves the date alone
      end
    endcase
  end

  // Year changes only on a January or December landing, where February does not matter
  assign valid_next = cdsc_pkg::date_ok({1'b0, day_next}, month_next, feb29_ok);

  // Advance the stored date on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= '0;
      month_reg <= '0;
      year_reg  <= '0;
    end else if (accept) begin
      day_reg   <= day_next;
      month_reg <= month_next;
      year_reg  <= year_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      day_out    <= day_next;
      month_out  <= month_next;
      year_out   <= LW'(year_next);
      date_valid <= valid_next;
    end
  end

  assign m_tdata = {1'b0, year_out, month_out, day_out};
  assign m_tuser = date_valid;

endmodule

/* sv/cdsc_checker.sv */
// Port-level checks for the date step counter, bound to the top level.
// Depends on cdsc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "calendar_date_step_counter_defines.svh"

module cdsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // Reset empties the result register
  `CDSC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  // Every accepted beat shows a result on the next cycle
  `CDSC_ASSERT(a_beat_result, s_tvalid && s_tready |=> m_tvalid, "accepted beat gave no result")

  // A stalled result holds its value
  `CDSC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // A load returns the loaded day and month
  `CDSC_ASSERT(a_load_echo, s_tvalid && s_tready && (s_tuser == cdsc_pkg::OP_LOAD) |=> (m_tdata[8:0] == $past(s_tdata[8:0])), "load did not store day and month")

  // A date flagged valid has a real month and a nonzero day
  `CDSC_ASSERT(a_valid_range, m_tvalid && m_tuser |-> (m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12), "valid flag on impossible date")

endmodule

bind calendar_date_step_counter cdsc_checker u_cdsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* bench/tb_calendar_date_step_counter.sv */
// Self-checking bench for calendar_date_step_counter: load, step and query beats
// go in, and every returned date is checked against a local calendar predictor.
// Depends on cdsc_pkg and the calendar_date_step_counter RTL.
`timescale 1ns / 1ps

module tb_calendar_date_step_counter;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [cdsc_pkg::OP_W-1:0]        op_t;
  typedef logic [cdsc_pkg::LOAD_YEAR_W-1:0] year_t;

  typedef struct packed {
    op_t              op;
    cdsc_pkg::day_t   day;
    cdsc_pkg::month_t month;
    year_t            year;
  } date_cmd_t;

  typedef struct packed {
    cdsc_pkg::day_t   day;
    cdsc_pkg::month_t month;
    year_t            year;
    logic             valid;
  } date_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // load_day[4:0], load_month[8:5], load_year[22:9], zero pad
  logic [1:0]  s_tuser = '0;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // day_out[4:0], month_out[8:5], year_out[22:9], zero pad
  logic        m_tuser;        // date_valid[0]

  // Pending beats, the predicted dates still owed, and the predictor state
  date_cmd_t    date_cmds[$];
  date_result_t expected_dates[$];
  cdsc_pkg::day_t   cal_day = '0;
  cdsc_pkg::month_t cal_month = '0;
  year_t            cal_year = '0;

  date_cmd_t    held_cmd;
  logic         beat_held = 1'b0;
  date_result_t got_date;
  date_result_t want_date;
  int           src_gap_pct = 0;
  int           sink_stall_pct = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  calendar_date_step_counter #(.YEAR_BITS(cdsc_pkg::LOAD_YEAR_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Calendar predictor ----------------------------------------------------

  // Century rule applies from 1582 on; earlier, 29 February always exists
  function automatic bit has_feb29(input int y);
    if (y < cdsc_pkg::GREG_START) return 1'b1;
    if (y % 4 != 0) return 1'b0;
    if (y % 400 == 0) return 1'b1;
    return (y % 100 != 0);
  endfunction

  // Days in month m (1..12) of year y
  function automatic int month_len(input int m, input int y);
    if (m == 2) return has_feb29(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit is_real_date(input int d, input int m, input int y);
    if (m < 1 || m > 12) return 1'b0;
    if (d < 1 || d > 31) return 1'b0;
    return d <= month_len(m, y);
  endfunction

  // Apply one accepted beat to the predicted date and queue the result
  task automatic predict_date(input date_cmd_t c);
    date_result_t r;
    int nd;
    case (c.op)
      cdsc_pkg::OP_LOAD: begin
        cal_day   = c.day;
        cal_month = c.month;
        cal_year  = c.year;
      end
      cdsc_pkg::OP_NEXT: begin
        nd = cal_day + 1;
        if (!is_real_date(nd, cal_month, cal_year)) begin
          cal_day   = 5'd1;
          cal_month = cal_month + 4'd1;
          if (!is_real_date(cal_day, cal_month, cal_year)) begin
            cal_month = 4'd1;
            cal_year  = cal_year + 1'b1;
          end
        end else begin
          cal_day = cdsc_pkg::day_t'(nd);
        end
      end
      cdsc_pkg::OP_PREV: begin
        nd = cal_day - 1;
        if (cal_day == 0 || !is_real_date(nd, cal_month, cal_year)) begin
          cal_day   = 5'd31;
          cal_month = cal_month - 4'd1;
          if (cal_month == 0) begin
            cal_month = 4'd12;
            cal_year  = cal_year - 1'b1;
          end else begin
            // walk down to the month's last day, never below day 1
            while (cal_day > 1 && !is_real_date(cal_day, cal_month, cal_year))
              cal_day = cal_day - 5'd1;
          end
        end else begin
          cal_day = cdsc_pkg::day_t'(nd);
        end
      end
      default: ;
    endcase
    r.day   = cal_day;
    r.month = cal_month;
    r.year  = cal_year;
    r.valid = is_real_date(cal_day, cal_month, cal_year);
    expected_dates.push_back(r);
  endtask

  // Stimulus --------------------------------------------------------------

  task automatic push_cmd(input op_t op, input int d, input int m, input int y);
    date_cmd_t c;
    c.op    = op;
    c.day   = cdsc_pkg::day_t'(d);
    c.month = cdsc_pkg::month_t'(m);
    c.year  = year_t'(y);
    date_cmds.push_back(c);
  endtask

  // Years around the leap rule edges and the wrap points
  function automatic int pick_year();
    case ($urandom_range(13))
      0:  return 0;
      1:  return 1;
      2:  return 1581;
      3:  return 1582;
      4:  return 1583;
      5:  return 1600;
      6:  return 1900;
      7:  return 2000;
      8:  return 2024;
      9:  return 2100;
      10: return 16383;
      11: return 16380;
      default: return $urandom_range(16383);
    endcase
  endfunction

  // Mostly well-formed dates near month edges; some with any field values
  function automatic date_cmd_t random_load();
    date_cmd_t c;
    int len;
    c.op    = cdsc_pkg::OP_LOAD;
    c.day   = cdsc_pkg::day_t'($urandom_range(31));
    c.month = cdsc_pkg::month_t'($urandom_range(15));
    c.year  = year_t'($urandom_range(16383));
    if ($urandom_range(4) != 0) begin
      c.year  = year_t'(pick_year());
      c.month = cdsc_pkg::month_t'($urandom_range(12, 1));
      len     = month_len(c.month, c.year);
      case ($urandom_range(2))
        0:       c.day = cdsc_pkg::day_t'(len - $urandom_range(1));
        1:       c.day = cdsc_pkg::day_t'($urandom_range(2, 1));
        default: c.day = cdsc_pkg::day_t'($urandom_range(len, 1));
      endcase
    end
    return c;
  endfunction

  task automatic queue_directed_items();
    push_cmd(cdsc_pkg::OP_QUERY, 0, 0, 0);          // reset date, invalid
    push_cmd(cdsc_pkg::OP_NEXT, 0, 0, 0);           // invalid month walks into January
    push_cmd(cdsc_pkg::OP_LOAD, 31, 12, 16383);     // last day of the last year
    push_cmd(cdsc_pkg::OP_NEXT, 0, 0, 0);           // year wraps forward to 0
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);           // and back again
    push_cmd(cdsc_pkg::OP_LOAD, 0, 0, 0);
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);           // day underflow, month 0 wraps to 15
    push_cmd(cdsc_pkg::OP_NEXT, 0, 0, 0);           // month 15 wraps to 0, then January
    push_cmd(cdsc_pkg::OP_LOAD, 31, 15, 16383);     // all-ones load
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);           // month with no valid day stops at 1
    push_cmd(cdsc_pkg::OP_LOAD, 29, 2, 1500);       // pre-Gregorian 29 February
    push_cmd(cdsc_pkg::OP_NEXT, 0, 0, 0);
    push_cmd(cdsc_pkg::OP_LOAD, 29, 2, 1900);       // century, not a leap year
    push_cmd(cdsc_pkg::OP_QUERY, 31, 15, 16383);
    push_cmd(cdsc_pkg::OP_LOAD, 1, 3, 2000);
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);           // 400-year leap
    push_cmd(cdsc_pkg::OP_LOAD, 1, 3, 1582);
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);
    push_cmd(cdsc_pkg::OP_LOAD, 31, 4, 2024);       // day 31 in a 30-day month
    push_cmd(cdsc_pkg::OP_NEXT, 0, 0, 0);
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);
    push_cmd(cdsc_pkg::OP_LOAD, 5, 13, 77);         // month above December
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);
    push_cmd(cdsc_pkg::OP_LOAD, 1, 1, 0);
    push_cmd(cdsc_pkg::OP_PREV, 0, 0, 0);           // year wraps back to the top
  endtask

  // Load-then-step runs with random content, plus some noise beats
  task automatic queue_random_items(input int count);
    date_cmd_t c;
    int left;
    int run;
    int sel;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        c.op    = op_t'($urandom_range(3));
        c.day   = cdsc_pkg::day_t'($urandom_range(31));
        c.month = cdsc_pkg::month_t'($urandom_range(15));
        c.year  = year_t'($urandom_range(16383));
        date_cmds.push_back(c);
        left--;
      end else begin
        date_cmds.push_back(random_load());
        left--;
        run = $urandom_range(40, 1);
        while (run > 0 && left > 0) begin
          sel     = $urandom_range(99);
          c.op    = (sel < 45) ? cdsc_pkg::OP_NEXT :
                    (sel < 85) ? cdsc_pkg::OP_PREV : cdsc_pkg::OP_QUERY;
          c.day   = cdsc_pkg::day_t'($urandom_range(31));
          c.month = cdsc_pkg::month_t'($urandom_range(15));
          c.year  = year_t'($urandom_range(16383));
          date_cmds.push_back(c);
          run--;
          left--;
        end
      end
    end
  endtask

  // Hold until every beat went out and every result came back
  task automatic wait_for_drain();
    while (date_cmds.size() != 0 || beat_held || expected_dates.size() != 0)
      @(posedge clk);
  endtask

  // Driver: present queued beats, predict on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_date(held_cmd);
        beat_held = 1'b0;
      end
      if (!beat_held) begin
        if (date_cmds.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          held_cmd  = date_cmds.pop_front();
          beat_held = 1'b1;
          s_tvalid <= 1'b1;
          s_tuser  <= held_cmd.op;
          s_tdata  <= {1'b0, held_cmd.year, held_cmd.month, held_cmd.day};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_date = {m_tdata[4:0], m_tdata[8:5], m_tdata[22:9], m_tuser};
        if (expected_dates.size() == 0) begin
          $display("%0t ERROR result with nothing expected: got %0d/%0d/%0d valid %0d",
                   $time, got_date.day, got_date.month, got_date.year, got_date.valid);
          mismatches++;
        end else begin
          want_date = expected_dates.pop_front();
          if (got_date.day !== want_date.day) begin
            $display("%0t ERROR day_out: expected %0d, got %0d",
                     $time, want_date.day, got_date.day);
            mismatches++;
          end
          if (got_date.month !== want_date.month) begin
            $display("%0t ERROR month_out: expected %0d, got %0d",
                     $time, want_date.month, got_date.month);
            mismatches++;
          end
          if (got_date.year !== want_date.year) begin
            $display("%0t ERROR year_out: expected %0d, got %0d",
                     $time, want_date.year, got_date.year);
            mismatches++;
          end
          if (got_date.valid !== want_date.valid) begin
            $display("%0t ERROR date_valid: expected %0d, got %0d",
                     $time, want_date.valid, got_date.valid);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sequence: reset, then three traffic phases separated by full drains
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    src_gap_pct    = 6;
    sink_stall_pct = 57;
    queue_directed_items();
    queue_random_items(510);
    wait_for_drain();

    src_gap_pct    = 57;
    sink_stall_pct = 6;
    queue_random_items(520);
    wait_for_drain();

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    queue_random_items(520);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
